FILE: design/lek_pkg.sv
// ----------------------------------------------------------------------------
// lek_pkg
// Shared types and constants for the line editor keystroke engine.
// ----------------------------------------------------------------------------
package lek_pkg;

    // Default buffer size and the most cells that are ever built; only 15 of them
    // can hold a character (the 4-bit length limit caps a line at 15 characters).
    localparam int BUFFER_SIZE_DEF = 16;
    localparam int CELL_CAP        = 16;

    // Key codes
    localparam logic [7:0] KEY_CTRL_A = 8'd1;
    localparam logic [7:0] KEY_CTRL_B = 8'd2;
    localparam logic [7:0] KEY_CTRL_D = 8'd4;
    localparam logic [7:0] KEY_CTRL_E = 8'd5;
    localparam logic [7:0] KEY_CTRL_F = 8'd6;
    localparam logic [7:0] KEY_CTRL_H = 8'd8;
    localparam logic [7:0] KEY_LF     = 8'd10;
    localparam logic [7:0] KEY_CR     = 8'd13;
    localparam logic [7:0] KEY_CTRL_N = 8'd14;
    localparam logic [7:0] KEY_CTRL_P = 8'd16;
    localparam logic [7:0] KEY_DEL    = 8'd127;
    localparam logic [7:0] KEY_FIRST  = 8'd32;   // space
    localparam logic [7:0] KEY_LASTP  = 8'd126;  // tilde

    // Echo bytes
    localparam logic [7:0] CH_BEL   = 8'd7;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_NONE  = 8'd0;

    // Result kinds
    localparam logic [2:0] KIND_ECHO   = 3'd0;
    localparam logic [2:0] KIND_PROMPT = 3'd1;
    localparam logic [2:0] KIND_CHAR   = 3'd2;
    localparam logic [2:0] KIND_END    = 3'd3;
    localparam logic [2:0] KIND_EOF    = 3'd4;

    localparam logic [3:0] MAX_LEN_RST = 4'd15;

    // Edit command broadcast to the cell row
    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_INS  = 2'd1,
        CMD_DEL  = 2'd2
    } cmd_t;

endpackage

FILE: design/lek_if.sv
// ----------------------------------------------------------------------------
// lek_if
// Valid/ready channels of the line editor: key in, results out, config write.
// ----------------------------------------------------------------------------
interface lek_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key;
    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

interface lek_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] byte_res;
    logic       last;
    modport source (output valid, output kind, output byte_res, output last, input ready);
    modport sink   (input valid, input kind, input byte_res, input last, output ready);
endinterface

interface lek_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/lek_cell.sv
// ----------------------------------------------------------------------------
// lek_cell
// One character cell of the line buffer; shifts with its neighbors on edits.
// ----------------------------------------------------------------------------
module lek_cell #(
    parameter int IDX = 0,
    parameter int PW  = 4
) (
    input  logic              clk,
    input  lek_pkg::cmd_t     cmd,
    input  logic [PW-1:0]     pos,
    input  logic [PW-1:0]     len,
    input  logic [7:0]        key,
    input  logic [7:0]        left_q,
    input  logic [7:0]        right_q,
    output logic [7:0]        q
);

    localparam logic [PW:0] MY_IDX = (PW+1)'(IDX);

    logic [7:0] q_reg;
    logic [7:0] q_next;
    logic [PW:0] pos_x;
    logic [PW:0] len_x;

    assign pos_x = {1'b0, pos};
    assign len_x = {1'b0, len};

    always_comb
    begin
        q_next = q_reg;
        case (cmd)
            lek_pkg::CMD_INS:
            begin
                // open a gap at pos: cells above it take their left neighbor
                if (MY_IDX == pos_x)
                begin
                    q_next = key;
                end
                else if (MY_IDX > pos_x && MY_IDX <= len_x)
                begin
                    q_next = left_q;
                end
            end
            lek_pkg::CMD_DEL:
            begin
                // close the gap at pos
                if (MY_IDX >= pos_x && MY_IDX + 1'b1 < len_x)
                begin
                    q_next = right_q;
                end
            end
            default:
            begin
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

FILE: design/line_editor_keystroke_engine.sv
// ----------------------------------------------------------------------------
// line_editor_keystroke_engine
// Emacs-style line editor: key bytes in, terminal redisplay and lines out.
// ----------------------------------------------------------------------------
// One key is taken at a time. The line lives in a row of byte cells; an
// insert or delete shifts the affected cells by one place in the cycle the
// key transfer happens, so the edit itself costs nothing extra. The block
// then walks a short list of phases (forward echo, move back or prompt,
// tail echo, blank-out, return backspaces; or CR, LF, line characters, line
// end), one result per cycle while the result sink holds ready high. It
// passes through a start state, loads each phase it reaches (up to five)
// and returns to idle; phases after the last one that has results are
// skipped. An ignored key produces no results and leaves the block idle.
// A key produces at most 31 results at the default size. A new key is
// taken after the last result of the previous key has been loaded into the
// output register and the sequencer has returned to idle. Configuration
// writes (max_length) are always taken and act on the next insertion.
// ----------------------------------------------------------------------------
module line_editor_keystroke_engine #(
    parameter int BUFFER_SIZE = lek_pkg::BUFFER_SIZE_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    lek_key_if.sink   keys,
    lek_res_if.source results,
    lek_cfg_if.sink   cfg
);

    // At most 16 cells are built; only the first 15 can ever be written (limit <= 15).
    localparam int NCELL = (BUFFER_SIZE < lek_pkg::CELL_CAP) ? BUFFER_SIZE
                                                             : lek_pkg::CELL_CAP;
    localparam int PW    = $clog2(NCELL);
    localparam int RW    = $clog2(3 * NCELL + 3);
    localparam logic [3:0] LIM_CAP = 4'(NCELL - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_FWD   = 4'd2;
    localparam logic [3:0] S_MOVE  = 4'd3;
    localparam logic [3:0] S_TAIL  = 4'd4;
    localparam logic [3:0] S_BLANK = 4'd5;
    localparam logic [3:0] S_BACK  = 4'd6;
    localparam logic [3:0] S_CR    = 4'd7;
    localparam logic [3:0] S_LF    = 4'd8;
    localparam logic [3:0] S_CHARS = 4'd9;
    localparam logic [3:0] S_END   = 4'd10;
    localparam logic [3:0] S_EOF   = 4'd11;
    localparam logic [3:0] S_BELL  = 4'd12;

    // what kind of work a key starts
    localparam logic [1:0] M_REDRAW = 2'd0;
    localparam logic [1:0] M_ENTER  = 2'd1;
    localparam logic [1:0] M_EOF    = 2'd2;
    localparam logic [1:0] M_BELL   = 2'd3;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [3:0]    state_reg, state_next;
    logic [1:0]    mode_reg, mode_next;
    logic [PW-1:0] cursor_reg, cursor_next;
    logic [PW-1:0] len_reg, len_next;
    logic [3:0]    max_len_reg, max_len_next;
    logic [PW-1:0] oc_reg, oc_next;     // cursor before the key
    logic [PW-1:0] np_reg, np_next;     // cursor after the key
    logic [PW-1:0] ol_reg, ol_next;     // length before the key
    logic [PW-1:0] nl_reg, nl_next;     // length after the key
    logic [PW-1:0] cnt_reg, cnt_next;   // results left in this phase
    logic [PW-1:0] ridx_reg, ridx_next; // cell read index
    logic [RW-1:0] rem_reg, rem_next;   // results left for this key
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    out_kind_reg, out_kind_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_last_reg, out_last_next;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    logic key_xfer;
    logic emit_ok;
    logic emit;

    assign keys.ready       = (state_reg == S_IDLE);
    assign key_xfer         = keys.valid && keys.ready;
    assign cfg.ready        = 1'b1;
    assign emit_ok          = !out_valid_reg || results.ready;
    assign results.valid    = out_valid_reg;
    assign results.kind     = out_kind_reg;
    assign results.byte_res = out_byte_reg;
    assign results.last     = out_last_reg;

    // ------------------------------------------------------------------
    // key decode (current cursor and length)
    // ------------------------------------------------------------------
    logic [3:0]     lim;
    logic [1:0]     dec_mode;
    logic [PW-1:0]  dec_np;
    logic [PW-1:0]  dec_nl;
    logic           dec_act;
    lek_pkg::cmd_t  dec_cmd;
    logic [PW-1:0]  dec_pos;
    logic           printable;

    assign lim       = (max_len_reg > LIM_CAP) ? LIM_CAP : max_len_reg;
    assign printable = (keys.key >= lek_pkg::KEY_FIRST) && (keys.key <= lek_pkg::KEY_LASTP);

    always_comb
    begin
        dec_mode = M_REDRAW;
        dec_np   = cursor_reg;
        dec_nl   = len_reg;
        dec_act  = 1'b1;
        dec_cmd  = lek_pkg::CMD_NONE;
        dec_pos  = cursor_reg;
        if (keys.key == lek_pkg::KEY_LF || keys.key == lek_pkg::KEY_CR)
        begin
            dec_mode = M_ENTER;
            dec_np   = '0;
            dec_nl   = '0;
        end
        else if (keys.key == lek_pkg::KEY_CTRL_A)
        begin
            dec_np = '0;
        end
        else if (keys.key == lek_pkg::KEY_CTRL_E)
        begin
            dec_np = len_reg;
        end
        else if (keys.key == lek_pkg::KEY_CTRL_B)
        begin
            if (cursor_reg != '0)
            begin
                dec_np = cursor_reg - 1'b1;
            end
            else
            begin
                dec_act = 1'b0;
            end
        end
        else if (keys.key == lek_pkg::KEY_CTRL_F)
        begin
            if (cursor_reg < len_reg)
            begin
                dec_np = cursor_reg + 1'b1;
            end
            else
            begin
                dec_act = 1'b0;
            end
        end
        else if (keys.key == lek_pkg::KEY_CTRL_D)
        begin
            if (cursor_reg < len_reg)
            begin
                dec_cmd = lek_pkg::CMD_DEL;
                dec_nl  = len_reg - 1'b1;
            end
            else if (cursor_reg == '0 && len_reg == '0)
            begin
                dec_mode = M_EOF;
            end
            else
            begin
                dec_act = 1'b0;
            end
        end
        else if (keys.key == lek_pkg::KEY_CTRL_H || keys.key == lek_pkg::KEY_DEL)
        begin
            if (cursor_reg != '0)
            begin
                dec_cmd = lek_pkg::CMD_DEL;
                dec_pos = cursor_reg - 1'b1;
                dec_np  = cursor_reg - 1'b1;
                dec_nl  = len_reg - 1'b1;
            end
            else
            begin
                dec_act = 1'b0;
            end
        end
        else if (keys.key == lek_pkg::KEY_CTRL_P || keys.key == lek_pkg::KEY_CTRL_N)
        begin
            dec_act = 1'b0;
        end
        else if (4'(len_reg) < lim && printable)
        begin
            dec_cmd = lek_pkg::CMD_INS;
            dec_np  = cursor_reg + 1'b1;
            dec_nl  = len_reg + 1'b1;
        end
        else
        begin
            dec_mode = M_BELL;
        end
    end

    // total result count for the decoded key
    logic [RW-1:0] r_fwd, r_mv, r_tail, r_blank, dec_rem;

    always_comb
    begin
        r_fwd   = (dec_np > cursor_reg) ? RW'(dec_np - cursor_reg) : '0;
        r_mv    = (dec_np > cursor_reg) ? '0 :
                  (dec_np == '0)        ? RW'(1) : RW'(cursor_reg - dec_np);
        r_tail  = RW'(dec_nl - dec_np);
        r_blank = (len_reg > dec_nl) ? RW'(len_reg - dec_nl) : '0;
        if (!dec_act)
        begin
            dec_rem = '0;
        end
        else
        begin
            case (dec_mode)
                M_ENTER:
                begin
                    dec_rem = RW'(len_reg) + RW'(3);
                end
                M_EOF, M_BELL:
                begin
                    dec_rem = RW'(1);
                end
                default:
                begin
                    // changed length: tail and blanks echoed, then as many backspaces
                    dec_rem = r_fwd + r_mv
                            + ((dec_nl != len_reg) ? ((r_tail + r_blank) << 1) : '0);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // cell row holding the line
    // ------------------------------------------------------------------
    logic [7:0]    cell_q [NCELL];
    lek_pkg::cmd_t cell_cmd;

    assign cell_cmd = key_xfer ? dec_cmd : lek_pkg::CMD_NONE;

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        logic [7:0] left_q;
        logic [7:0] right_q;
        if (g == 0)
        begin : g_first
            assign left_q = 8'h00;
        end
        else
        begin : g_mid_l
            assign left_q = cell_q[g-1];
        end
        if (g == NCELL - 1)
        begin : g_last
            assign right_q = 8'h00;
        end
        else
        begin : g_mid_r
            assign right_q = cell_q[g+1];
        end
        lek_cell #(
            .IDX (g),
            .PW  (PW)
        ) u_cell (
            .clk     (clk),
            .cmd     (cell_cmd),
            .pos     (dec_pos),
            .len     (len_reg),
            .key     (keys.key),
            .left_q  (left_q),
            .right_q (right_q),
            .q       (cell_q[g])
        );
    end

    // ------------------------------------------------------------------
    // phase order and phase counts
    // ------------------------------------------------------------------
    logic [3:0]    nxt;
    logic [PW-1:0] seed_cnt;
    logic [PW-1:0] seed_ridx;
    logic          chg;

    assign chg = (nl_reg != ol_reg);

    always_comb
    begin
        unique case (state_reg)
            S_START:
            begin
                case (mode_reg)
                    M_ENTER: nxt = S_CR;
                    M_EOF:   nxt = S_EOF;
                    M_BELL:  nxt = S_BELL;
                    default: nxt = S_FWD;
                endcase
            end
            S_FWD:   nxt = S_MOVE;
            S_MOVE:  nxt = S_TAIL;
            S_TAIL:  nxt = S_BLANK;
            S_BLANK: nxt = S_BACK;
            S_CR:    nxt = S_LF;
            S_LF:    nxt = S_CHARS;
            S_CHARS: nxt = S_END;
            default: nxt = S_IDLE;
        endcase
    end

    always_comb
    begin
        seed_ridx = np_reg;
        seed_cnt  = PW'(1);
        case (nxt)
            S_FWD:
            begin
                seed_ridx = oc_reg;
                seed_cnt  = (np_reg > oc_reg) ? (np_reg - oc_reg) : '0;
            end
            S_MOVE:
            begin
                seed_cnt = (np_reg > oc_reg) ? '0 :
                           (np_reg == '0)    ? PW'(1) : (oc_reg - np_reg);
            end
            S_TAIL:
            begin
                seed_cnt = chg ? (nl_reg - np_reg) : '0;
            end
            S_BLANK:
            begin
                seed_cnt = (chg && ol_reg > nl_reg) ? (ol_reg - nl_reg) : '0;
            end
            S_BACK:
            begin
                seed_cnt = !chg ? '0 :
                           (ol_reg > nl_reg) ? (ol_reg - np_reg) : (nl_reg - np_reg);
            end
            S_CHARS:
            begin
                seed_ridx = '0;
                seed_cnt  = ol_reg;
            end
            default:
            begin
                seed_cnt = PW'(1);
            end
        endcase
    end

    // ------------------------------------------------------------------
    // result byte for the current phase
    // ------------------------------------------------------------------
    logic [2:0] cur_kind;
    logic [7:0] cur_byte;

    always_comb
    begin
        cur_kind = lek_pkg::KIND_ECHO;
        cur_byte = lek_pkg::CH_NONE;
        case (state_reg)
            S_FWD, S_TAIL:
            begin
                cur_byte = cell_q[ridx_reg];
            end
            S_CHARS:
            begin
                cur_kind = lek_pkg::KIND_CHAR;
                cur_byte = cell_q[ridx_reg];
            end
            S_MOVE:
            begin
                if (np_reg == '0)
                begin
                    cur_kind = lek_pkg::KIND_PROMPT;
                end
                else
                begin
                    cur_byte = lek_pkg::CH_BS;
                end
            end
            S_BLANK: cur_byte = lek_pkg::CH_SPACE;
            S_BACK:  cur_byte = lek_pkg::CH_BS;
            S_CR:    cur_byte = lek_pkg::CH_CR;
            S_LF:    cur_byte = lek_pkg::CH_LF;
            S_END:   cur_kind = lek_pkg::KIND_END;
            S_EOF:   cur_kind = lek_pkg::KIND_EOF;
            S_BELL:  cur_byte = lek_pkg::CH_BEL;
            default:
            begin
                cur_kind = lek_pkg::KIND_ECHO;
                cur_byte = lek_pkg::CH_NONE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        cursor_next  = cursor_reg;
        len_next     = len_reg;
        oc_next      = oc_reg;
        np_next      = np_reg;
        ol_next      = ol_reg;
        nl_next      = nl_reg;
        cnt_next     = cnt_reg;
        ridx_next    = ridx_reg;
        rem_next     = rem_reg;
        emit         = 1'b0;
        max_len_next = (cfg.valid && cfg.ready) ? cfg.data : max_len_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (key_xfer)
                begin
                    cursor_next = dec_np;
                    len_next    = dec_nl;
                    oc_next     = cursor_reg;
                    np_next     = dec_np;
                    ol_next     = len_reg;
                    nl_next     = dec_nl;
                    mode_next   = dec_mode;
                    rem_next    = dec_rem;
                    cnt_next    = '0;
                    if (dec_rem != '0)
                    begin
                        state_next = S_START;
                    end
                end
            end
            default:
            begin
                if (rem_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = nxt;
                    cnt_next   = seed_cnt;
                    ridx_next  = seed_ridx;
                end
                else if (emit_ok)
                begin
                    emit      = 1'b1;
                    cnt_next  = cnt_reg - 1'b1;
                    ridx_next = ridx_reg + 1'b1;
                    rem_next  = rem_reg - 1'b1;
                end
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = cur_kind;
            out_byte_next  = cur_byte;
            out_last_next  = (rem_reg == RW'(1));
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_REDRAW;
            cursor_reg    <= '0;
            len_reg       <= '0;
            max_len_reg   <= lek_pkg::MAX_LEN_RST;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            cursor_reg    <= cursor_next;
            len_reg       <= len_next;
            max_len_reg   <= max_len_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        oc_reg       <= oc_next;
        np_reg       <= np_next;
        ol_reg       <= ol_next;
        nl_reg       <= nl_next;
        ridx_reg     <= ridx_next;
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule
